[rtl/ids_pkg.sv]
// package for the integer-factor image downscaler
// shared constants, register indexes and the lane control struct; no dependencies
package ids_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_FACTOR_DEF = 16;

  localparam int PIX_W   = 8;
  localparam int QUOT_W  = 8;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W   = 13;
  localparam int SCALE_W = 5;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

  // reset values
  localparam logic [SCALE_W-1:0] SCALE_RST  = 5'd2;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;

  // gaussian kernel weights sum to this
  localparam int GAUSS_DIV = 16;

  typedef struct packed {
    logic start;  // latch the updated sum and load the divider
    logic step;   // one restoring division step
  } lane_ctrl_t;

endpackage

[rtl/image_downscale_box_gauss.sv]
// top level of the integer-factor image downscaler
// depends on ids_pkg and ids_lane
//
// usage
//   pixels enter in raster order on the s_ request channel, one per request,
//   s_tdata = {blue, green, red_or_gray}; green and blue are ignored in grey mode
//   the frame is cut into factor x factor blocks, partial blocks at the right
//   and bottom are dropped; even factors give the block mean, odd factors the
//   1-2-1 gaussian over the block's top-left 3x3 window divided by 16
//   one result leaves on the m_ channel for the last pixel of each whole block,
//   m_tlast marks the last pixel of an output row, m_tuser the last of the frame
//   configuration is written by the user through cfg_we/cfg_index/cfg_data while
//   idle, a rule the block does not enforce; any write restarts the frame position
// sequence
//   each pixel is taken in the idle state with its column sum read from the memory,
//   then updated and written back in the update state; a block-ending pixel then
//   runs the bit-serial divider in each of the three colour lanes and waits in
//   the hold state to load the output register; no new pixel is taken meanwhile
//   the output register parts the two sides; if the receiver stalls the block
//   keeps taking pixels until its next result is ready, then waits with s_tready
//   low until the result register is free
// reset
//   rst (synchronous) clears the position counters, the registers to their
//   defaults and the output valid; the column-sum memory is not cleared since
//   the first pixel of every block overwrites its entry
module image_downscale_box_gauss #(
  parameter int MAX_WIDTH  = ids_pkg::MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = ids_pkg::MAX_FACTOR_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // pixel input
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // red_or_gray, green, blue
  // scaled pixel output
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,   // out_red_or_gray, out_green, out_blue
  output logic                           m_tlast,   // row_end
  output logic [0:0]                     m_tuser,   // frame_end
  // configuration
  input  logic                           cfg_we,
  input  logic [ids_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ids_pkg::CFG_W-1:0]      cfg_data
);
  import ids_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int OCW   = XW - 1;
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int FW    = $clog2(MAX_FACTOR);
  localparam int FEW   = $clog2(MAX_FACTOR + 1);
  localparam int SUM_W = PIX_W + 2 * $clog2(MAX_FACTOR);
  localparam int DIV_W = (2 * FW + 1 > 5) ? 2 * FW + 1 : 5;
  localparam int SCW   = $clog2(QUOT_W);
  localparam int XBW   = XW + 2;
  localparam int YBW   = DIM_W + 2;

  typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_DIV, S_HOLD} state_t;

  // configuration registers
  logic [SCALE_W-1:0] scale_reg;
  logic               color_reg;
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;

  // raster position
  logic [XW-1:0]    x;
  logic [DIM_W-1:0] y;
  logic [FW-1:0]    cx;
  logic [FW-1:0]    ry;
  logic [OCW-1:0]   oc;

  logic [FW-1:0]    cx_next, ry_next;
  logic [XW-1:0]    x_next;
  logic [DIM_W-1:0] y_next;
  logic [OCW-1:0]   oc_next;

  // effective settings
  logic [FEW-1:0]   f_eff;
  logic [XW:0]      w_eff;
  logic [DIM_W-1:0] h_eff;

  logic [XBW-1:0] x_blk_end;
  logic [YBW-1:0] y_blk_end;
  logic           in_block, last_px, row_end_c, frame_end_c;
  logic [2:0]     weight_c;
  logic           accept;
  logic           out_load;

  // per-request captured values
  state_t         state;
  logic [SCW-1:0] step_cnt;
  logic [PIX_W-1:0] px_r [3];
  logic [2:0]     weight_r;
  logic           first_r, wr_en_r, produce_r, row_end_r, frame_end_r;
  logic [OCW-1:0] addr_r;
  logic [DIV_W-1:0] divisor_r;

  // column sums, one 3-channel word per output column
  logic [3*SUM_W-1:0] sum_mem [DEPTH];
  logic [3*SUM_W-1:0] rd_data;
  logic [3*SUM_W-1:0] wr_data;

  lane_ctrl_t ctrl;
  logic [QUOT_W-1:0] quot [3];

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  // result register takes the quotients once it is empty or being drained
  assign out_load = (state == S_HOLD) && (!m_tvalid || m_tready);

  // clamp the programmed factor, width and height
  always_comb begin
    if (32'(scale_reg) < 2) begin
      f_eff = FEW'(2);
    end else if (32'(scale_reg) > MAX_FACTOR) begin
      f_eff = FEW'(MAX_FACTOR);
    end else begin
      f_eff = FEW'(scale_reg);
    end
    if (width_reg == '0) begin
      w_eff = (XW+1)'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      w_eff = (XW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (XW+1)'(width_reg);
    end
    h_eff = (height_reg == '0) ? DIM_W'(1) : height_reg;
  end

  // a pixel counts only if its whole block lies inside the frame
  assign x_blk_end = XBW'(x) + XBW'(f_eff) - XBW'(1) - XBW'(cx);
  assign y_blk_end = YBW'(y) + YBW'(f_eff) - YBW'(1) - YBW'(ry);
  assign in_block  = (x_blk_end < XBW'(w_eff)) && (y_blk_end < YBW'(h_eff));
  assign last_px   = (FEW'(cx) == f_eff - FEW'(1)) && (FEW'(ry) == f_eff - FEW'(1));
  // no further whole block to the right / below
  assign row_end_c   = (XBW'(x) + XBW'(f_eff)) >= XBW'(w_eff);
  assign frame_end_c = row_end_c && ((YBW'(y) + YBW'(f_eff)) >= YBW'(h_eff));

  // box mean weighs every pixel 1; gaussian uses 1-2-1 x 1-2-1 on the top-left 3x3
  always_comb begin
    if (!f_eff[0]) begin
      weight_c = 3'd1;
    end else if (32'(cx) < 3 && 32'(ry) < 3) begin
      weight_c = 3'd1 << ((32'(cx) == 1 ? 1 : 0) + (32'(ry) == 1 ? 1 : 0));
    end else begin
      weight_c = 3'd0;
    end
  end

  // raster advance
  always_comb begin
    cx_next = ((FEW'(cx) + FEW'(1)) >= f_eff) ? '0 : cx + FW'(1);
    oc_next = ((FEW'(cx) + FEW'(1)) >= f_eff) ? oc + OCW'(1) : oc;
    ry_next = ry;
    y_next  = y;
    x_next  = x + XW'(1);
    if ((XW+1)'(x) + (XW+1)'(1) >= w_eff) begin
      x_next  = '0;
      cx_next = '0;
      oc_next = '0;
      ry_next = ((FEW'(ry) + FEW'(1)) >= f_eff) ? '0 : ry + FW'(1);
      y_next  = y + DIM_W'(1);
      if ((DIM_W+1)'(y) + (DIM_W+1)'(1) >= (DIM_W+1)'(h_eff)) begin
        y_next  = '0;
        ry_next = '0;
      end
    end
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_reg  <= SCALE_RST;
      color_reg  <= 1'b0;
      width_reg  <= WIDTH_RST;
      height_reg <= HEIGHT_RST;
      x  <= '0;
      y  <= '0;
      cx <= '0;
      ry <= '0;
      oc <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
        REG_COLOR:  color_reg  <= cfg_data[0];
        REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
      x  <= '0;
      y  <= '0;
      cx <= '0;
      ry <= '0;
      oc <= '0;
    end else if (accept) begin
      x  <= x_next;
      y  <= y_next;
      cx <= cx_next;
      ry <= ry_next;
      oc <= oc_next;
    end
  end

  // request payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r[0]     <= s_tdata[7:0];
      px_r[1]     <= color_reg ? s_tdata[15:8] : '0;
      px_r[2]     <= color_reg ? s_tdata[23:16] : '0;
      weight_r    <= weight_c;
      first_r     <= (cx == '0) && (ry == '0);
      addr_r      <= oc;
      row_end_r   <= row_end_c;
      frame_end_r <= frame_end_c;
      divisor_r   <= f_eff[0] ? DIV_W'(GAUSS_DIV) : DIV_W'(f_eff) * DIV_W'(f_eff);
    end
  end

  // column-sum memory: read on request, written back in the next cycle
  always_ff @(posedge clk) begin
    if (state == S_UPDATE && wr_en_r) begin
      sum_mem[addr_r] <= wr_data;
    end
    if (accept) begin
      rd_data <= sum_mem[oc];
    end
  end

  assign ctrl.start = (state == S_UPDATE);
  assign ctrl.step  = (state == S_DIV);

  for (genvar l = 0; l < 3; l++) begin : g_lane
    ids_lane #(
      .SUM_W (SUM_W),
      .DIV_W (DIV_W)
    ) u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .pixel    (px_r[l]),
      .weight   (weight_r),
      .first    (first_r),
      .old_sum  (rd_data[l*SUM_W +: SUM_W]),
      .divisor  (divisor_r),
      .new_sum  (wr_data[l*SUM_W +: SUM_W]),
      .quotient (quot[l])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      wr_en_r   <= 1'b0;
      produce_r <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            wr_en_r   <= in_block;
            produce_r <= in_block && last_px;
            state     <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          step_cnt <= '0;
          state    <= produce_r ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          step_cnt <= step_cnt + SCW'(1);
          if (step_cnt == SCW'(QUOT_W - 1)) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_load) begin
            m_tdata  <= {quot[2], quot[1], quot[0]};
            m_tlast  <= row_end_r;
            m_tuser  <= frame_end_r;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[0] || m_tlast))
    else $error("frame end without row end");

  a_request_to_update: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_UPDATE))
    else $error("accepted pixel did not reach the update step");

  a_result_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_HOLD))
    else $error("result loaded outside the hold step");
`endif

endmodule

[rtl/ids_lane.sv]
// one colour lane: weighted sum update and an iterative restoring divider
// depends on ids_pkg
module ids_lane #(
  parameter int SUM_W = 16,
  parameter int DIV_W = 9
) (
  input  logic                     clk,
  input  ids_pkg::lane_ctrl_t      ctrl,
  input  logic [ids_pkg::PIX_W-1:0] pixel,
  input  logic [2:0]               weight,
  input  logic                     first,
  input  logic [SUM_W-1:0]         old_sum,
  input  logic [DIV_W-1:0]         divisor,
  output logic [SUM_W-1:0]         new_sum,
  output logic [ids_pkg::QUOT_W-1:0] quotient
);
  import ids_pkg::*;

  localparam int CW = (SUM_W > DIV_W + QUOT_W - 1) ? SUM_W : DIV_W + QUOT_W - 1;

  logic [PIX_W+2:0] term;
  logic [CW-1:0]    rem;
  logic [CW-1:0]    dsh;

  assign term    = (PIX_W+3)'(pixel) * (PIX_W+3)'(weight);
  assign new_sum = first ? SUM_W'(term) : old_sum + SUM_W'(term);

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem      <= CW'(new_sum);
      dsh      <= CW'(divisor) << (QUOT_W - 1);
      quotient <= '0;
    end else if (ctrl.step) begin
      if (rem >= dsh) begin
        rem      <= rem - dsh;
        quotient <= {quotient[QUOT_W-2:0], 1'b1};
      end else begin
        quotient <= {quotient[QUOT_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

[tb/tb_image_downscale_box_gauss.sv]
// self-checking testbench for the integer-factor image downscaler
// holds its own downscale predictor, a queued pixel driver and a result monitor
// depends on ids_pkg and image_downscale_box_gauss
`timescale 1ns / 100ps

module tb_image_downscale_box_gauss;
  import ids_pkg::*;

  localparam int SUM_DEPTH   = MAX_WIDTH_DEF / 2;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 400;

  // one expected scaled pixel
  typedef struct packed {
    logic [7:0] red_or_gray;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } scaled_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic m_tlast;
  logic [0:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SCALE;
  logic [CFG_W-1:0] cfg_data = '0;

  image_downscale_box_gauss dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers and the raster position
  logic [SCALE_W-1:0] pr_factor = SCALE_RST;
  logic               pr_color  = 1'b0;
  logic [DIM_W-1:0]   pr_width  = WIDTH_RST;
  logic [DIM_W-1:0]   pr_height = HEIGHT_RST;
  int unsigned pos_x, pos_y, blk_col, blk_row;
  int unsigned col_sum [SUM_DEPTH][3];

  logic [23:0] pending_px[$];   // pixels waiting for the driver
  scaled_px_t  scaled_q[$];     // scaled pixels still owed by the block

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned phases_run = 0;
  int unsigned cycles = 0;
  logic in_taken = 1'b0;

  // works out the scaled pixel, if any, that one accepted request causes
  function automatic void predict_scaled(logic [23:0] d);
    int unsigned f, w, h, used_w, used_h, oc, weight, divisor;
    int unsigned px [3];
    bit odd;
    scaled_px_t res;
    f = (pr_factor < 2) ? 2 : (pr_factor > MAX_FACTOR_DEF) ? MAX_FACTOR_DEF : pr_factor;
    w = (pr_width < 1) ? 1 : (pr_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : pr_width;
    h = (pr_height < 1) ? 1 : pr_height;
    used_w = w - (w % f);
    used_h = h - (h % f);
    odd = f[0];
    px[0] = d[7:0];
    px[1] = pr_color ? d[15:8] : 0;
    px[2] = pr_color ? d[23:16] : 0;
    if (pos_x < used_w && pos_y < used_h) begin
      oc = pos_x / f;
      // gaussian kernel covers only the block's top-left 3x3 corner
      if (!odd) weight = 1;
      else if (blk_col < 3 && blk_row < 3)
        weight = (blk_col == 1 ? 2 : 1) * (blk_row == 1 ? 2 : 1);
      else weight = 0;
      for (int c = 0; c < 3; c++)
        col_sum[oc][c] = (blk_col == 0 && blk_row == 0) ? weight * px[c]
                                                         : col_sum[oc][c] + weight * px[c];
      if (blk_col == f - 1 && blk_row == f - 1) begin
        divisor = odd ? GAUSS_DIV : f * f;
        res.red_or_gray = 8'(col_sum[oc][0] / divisor);
        res.green       = 8'(col_sum[oc][1] / divisor);
        res.blue        = 8'(col_sum[oc][2] / divisor);
        res.row_end     = (pos_x == used_w - 1);
        res.frame_end   = (pos_x == used_w - 1) && (pos_y == used_h - 1);
        scaled_q.push_back(res);
      end
    end
    // raster advance, wrapping at the end of the frame
    blk_col = (blk_col + 1 >= f) ? 0 : blk_col + 1;
    pos_x++;
    if (pos_x >= w) begin
      pos_x = 0;
      blk_col = 0;
      blk_row = (blk_row + 1 >= f) ? 0 : blk_row + 1;
      pos_y++;
      if (pos_y >= h) begin
        pos_y = 0;
        blk_row = 0;
      end
    end
  endfunction

  // input side: note acceptance at the rising edge and predict there
  always @(posedge clk) begin
    in_taken <= s_tvalid && s_tready && !rst;
    if (!rst && s_tvalid && s_tready) begin
      predict_scaled(s_tdata);
      pixels_sent++;
    end
  end

  // pixel driver, new request offered at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_px.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= pending_px.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here on request from the sequence
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (hold_req != hold_served) begin
      hold_served <= hold_req;
      hold_left   <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver ready with random stalls
  always @(negedge clk) begin
    if (rst || hold_left > 0 || hold_req != hold_served) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor, compares each scaled pixel with the oldest expectation
  always @(posedge clk) begin
    scaled_px_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast, m_tuser[0]};
      results_seen++;
      if (scaled_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected scaled pixel %h at cycle %0d", got, cycles);
      end else begin
        want = scaled_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at cycle %0d: exp %h %h %h %b %b, got %h %h %h %b %b",
                     cycles, want.red_or_gray, want.green, want.blue, want.row_end,
                     want.frame_end, got.red_or_gray, got.green, got.blue, got.row_end,
                     got.frame_end);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, scaled_q.size());
      $display("image_downscale_box_gauss regression: fail");
      $finish;
    end
  end

  // wait until the block has drained, then let the divider tail pass
  task automatic wait_drained();
    while (pending_px.size() > 0 || s_tvalid || scaled_q.size() > 0 || hold_left > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_SCALE:  pr_factor = val[SCALE_W-1:0];
      REG_COLOR:  pr_color  = val[0];
      REG_WIDTH:  pr_width  = val;
      REG_HEIGHT: pr_height = val;
    endcase
    // any write restarts the frame
    pos_x = 0; pos_y = 0; blk_col = 0; blk_row = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one phase: registers, idling pattern, then a batch of pixels
  // kind 0 random pixels, 1 alternating black/white, 2 saturated white
  task automatic run_phase(int unsigned factor, int unsigned color, int unsigned width,
                           int unsigned height, int unsigned count, int unsigned kind);
    wait_drained();
    write_reg(REG_SCALE, CFG_W'(factor));
    write_reg(REG_COLOR, CFG_W'(color));
    write_reg(REG_WIDTH, CFG_W'(width));
    write_reg(REG_HEIGHT, CFG_W'(height));
    case (phases_run % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default: begin send_idle_pct = 17; recv_stall_pct = 17; end
    endcase
    phases_run++;
    for (int i = 0; i < count; i++) begin
      case (kind)
        1: pending_px.push_back(i[0] ? 24'hffffff : 24'h000000);
        2: pending_px.push_back(24'hffffff);
        default: pending_px.push_back(24'($urandom));
      endcase
    end
  endtask

  initial begin
    int unsigned f, w, h;
    for (int i = 0; i < SUM_DEPTH; i++)
      for (int c = 0; c < 3; c++) col_sum[i][c] = 0;
    pos_x = 0; pos_y = 0; blk_col = 0; blk_row = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: box mean on black/white, gaussian on full white, out-of-range registers
    run_phase(2, 0, 4, 4, 16, 1);
    run_phase(3, 1, 6, 3, 18, 2);
    run_phase(0, 1, 0, 0, 4, 0);        // factor, width and height below range
    run_phase(1, 1, 1, 4096, 20, 0);    // narrower than a block, 4096 rows high
    run_phase(17, 1, 16, 16, 256, 0);   // factor above range acts as the largest
    run_phase(31, 0, 16, 17, 16, 0);    // factor clamps to the largest, only the first row is sent
    run_phase(2, 1, 8191, 2, 64, 0);    // width clamps to the widest row
    run_phase(16, 0, 16, 16, 256, 2);

    // back-pressure: receiver holds off while pixels keep coming
    run_phase(2, 1, 8, 8, 128, 0);
    hold_req++;

    // random configurations, mostly small so that blocks complete often
    for (int p = 0; p < 6; p++) begin
      f = ($urandom_range(3) == 0) ? $urandom_range(16, 2) : $urandom_range(5, 2);
      w = $urandom_range(40, 1);
      h = $urandom_range(24, 1);
      run_phase(f, $urandom_range(1), w, h, $urandom_range(150, 60), 0);
    end
    run_phase(2, 1, 640, 480, 40, 0);
    wait_drained();

    $display("covered %0d phases, %0d pixels in, %0d scaled pixels out, %0d mismatches",
             phases_run, pixels_sent, results_seen, mismatches);
    if (mismatches == 0 && scaled_q.size() == 0)
      $display("image_downscale_box_gauss regression: pass");
    else
      $display("image_downscale_box_gauss regression: fail");
    $finish;
  end

endmodule
